### sv/eti_pkg.sv
// ---------------------------------------------------------------------------
// eti_pkg: shared types and constants of the escape-time iteration block
// Fixed-point format, command and status groups between control and datapath.
// ---------------------------------------------------------------------------
package eti_pkg;

  localparam int WordBits  = 32;
  localparam int FracBits  = 24;
  localparam int CountBits = 16;
  localparam int RadiusBits = 31;
  localparam int ProdBits  = 2 * WordBits;

  typedef logic signed [WordBits-1:0]  word_t;
  typedef logic signed [ProdBits-1:0]  prod_t;
  typedef logic        [CountBits-1:0] count_t;
  typedef logic        [RadiusBits-1:0] radius_t;

  localparam word_t   WordMax   = {1'b0, {(WordBits-1){1'b1}}};
  localparam word_t   WordMin   = {1'b1, {(WordBits-1){1'b0}}};
  localparam count_t  CountMax  = {CountBits{1'b1}};

  localparam count_t  MaxIterReset = 16'd50000;
  localparam radius_t RadiusReset  = 31'd67108864;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_MAX_ITER = 1'b0,
    CFG_RADIUS   = 1'b1
  } cfg_index_t;

  // controller to datapath
  typedef struct packed {
    logic start;    // load c, clear orbit and count
    logic advance;  // take one step of the map
    logic load_out; // capture the result into the output register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic finish;   // limit reached or orbit escaped
  } dp_stat_t;

  // saturate a wide value to the word range
  function automatic word_t sat_prod(input prod_t v);
    logic all_one;
    logic all_zero;
    all_one  = &v[ProdBits-1:WordBits-1];
    all_zero = ~|v[ProdBits-1:WordBits-1];
    if (all_one || all_zero) begin
      return v[WordBits-1:0];
    end else if (v[ProdBits-1]) begin
      return WordMin;
    end else begin
      return WordMax;
    end
  endfunction

  // saturating add and subtract of two words
  function automatic word_t sat_add(input word_t a, input word_t b);
    logic signed [WordBits:0] s;
    s = {a[WordBits-1], a} + {b[WordBits-1], b};
    if (s[WordBits] != s[WordBits-1]) begin
      return s[WordBits] ? WordMin : WordMax;
    end
    return s[WordBits-1:0];
  endfunction

  function automatic word_t sat_sub(input word_t a, input word_t b);
    logic signed [WordBits:0] s;
    s = {a[WordBits-1], a} - {b[WordBits-1], b};
    if (s[WordBits] != s[WordBits-1]) begin
      return s[WordBits] ? WordMin : WordMax;
    end
    return s[WordBits-1:0];
  endfunction

endpackage

### sv/escape_time_iteration.sv
// ---------------------------------------------------------------------------
// escape_time_iteration: Mandelbrot escape-time count for one point c
// Iterates z = z*z + c from z = 0 in saturating signed Q8.24 fixed point.
// ---------------------------------------------------------------------------
//
//  channel   dir  fields (lowest bit up)                 handshake
//  --------  ---  -------------------------------------  ----------------
//  s_*       in   c_real[31:0], c_imag[63:32]            tvalid / tready
//  m_*       out  iterations[15:0], escaped[16], 0 pad   tvalid / tready
//  cfg_*     in   index 0 max_iterations, 1 radius sq    cfg_we only
//
//  In each iteration ST_MUL registers the three 32x32 products, and
//  ST_CHK saturates them, tests the escape condition and updates z.
//  Reset (rst, synchronous) restores max_iterations 50000 and radius 4.0.
//  The result waits in an output register; the next point is accepted
//  while it waits, and a finished point holds until that register frees.
//
module escape_time_iteration (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [30:0] cfg_data,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // c_real[31:0], c_imag[63:32]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // iterations[15:0], escaped[16], zero[23:17]
);
  import eti_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  count_t   iterations;
  logic     escaped;

  // step sequencing and both handshakes
  eti_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // orbit arithmetic, configuration and result register
  eti_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .c_real     (s_tdata[31:0]),
    .c_imag     (s_tdata[63:32]),
    .cmd        (cmd),
    .stat       (stat),
    .iterations (iterations),
    .escaped    (escaped)
  );

  // pack the result beat, zero fill to a whole byte
  assign m_tdata = {7'd0, escaped, iterations};

endmodule

### sv/eti_dp.sv
// ---------------------------------------------------------------------------
// eti_dp: datapath of the escape-time iteration
// Orbit registers, registered squares and cross product, update and result.
// ---------------------------------------------------------------------------
module eti_dp (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  input  eti_pkg::word_t     c_real,
  input  eti_pkg::word_t     c_imag,
  input  eti_pkg::dp_cmd_t   cmd,
  output eti_pkg::dp_stat_t  stat,
  output eti_pkg::count_t    iterations,
  output logic               escaped
);
  import eti_pkg::*;

  count_t  max_iter;
  radius_t radius;
  word_t   c_re;
  word_t   c_im;
  word_t   z_re;
  word_t   z_im;
  count_t  cnt;
  prod_t   pxx;
  prod_t   pyy;
  prod_t   pxy;

  word_t   xx;
  word_t   yy;
  word_t   xy2;
  word_t   mag;
  word_t   diff;
  word_t   z_re_next;
  word_t   z_im_next;
  logic    mag_out;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_iter <= MaxIterReset;
      radius   <= RadiusReset;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_MAX_ITER: max_iter <= cfg_data[CountBits-1:0];
        CFG_RADIUS:   radius   <= cfg_data[RadiusBits-1:0];
        default:      ;
      endcase
    end
  end

  // products of the current orbit point
  always_ff @(posedge clk) begin
    pxx <= prod_t'(z_re) * prod_t'(z_re);
    pyy <= prod_t'(z_im) * prod_t'(z_im);
    pxy <= prod_t'(z_re) * prod_t'(z_im);
  end

  always_comb begin
    xx        = sat_prod(pxx >>> FracBits);
    yy        = sat_prod(pyy >>> FracBits);
    xy2       = sat_prod(pxy >>> (FracBits - 1));
    mag       = sat_add(xx, yy);
    diff      = sat_sub(xx, yy);
    z_re_next = sat_add(diff, c_re);
    z_im_next = sat_add(xy2, c_im);
    // mag is never negative, so an unsigned compare is safe
    mag_out   = {1'b0, $unsigned(mag[WordBits-2:0])} >= {1'b0, radius} || mag[WordBits-1];
    stat.finish = (cnt >= max_iter) || (cnt == CountMax) || mag_out;
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      c_re <= c_real;
      c_im <= c_imag;
      z_re <= '0;
      z_im <= '0;
      cnt  <= '0;
    end else if (cmd.advance) begin
      z_re <= z_re_next;
      z_im <= z_im_next;
      cnt  <= cnt + count_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      iterations <= cnt;
      escaped    <= cnt < max_iter;
    end
  end

endmodule

### sv/eti_ctrl.sv
// ---------------------------------------------------------------------------
// eti_ctrl: controller of the escape-time iteration
// Sequences multiply and check cycles and owns both handshakes.
// ---------------------------------------------------------------------------
module eti_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  output eti_pkg::dp_cmd_t   cmd,
  input  eti_pkg::dp_stat_t  stat
);
  import eti_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHK,
    ST_HOLD
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;
  // take no beat while reset is held
  assign s_tready = (state == ST_IDLE) && !rst;

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: cmd.start    = s_tvalid;
      ST_MUL:  ;
      ST_CHK: begin
        cmd.advance  = !stat.finish;
        cmd.load_out = stat.finish && out_free;
      end
      ST_HOLD: cmd.load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: state <= ST_CHK;
        ST_CHK: begin
          if (!stat.finish) begin
            state <= ST_MUL;
          end else if (out_free) begin
            state <= ST_IDLE;
          end else begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for the escape-time iteration block
// Streams points c into the block, predicts the escape count and escaped
// flag of each point in fixed point, and checks every result beat in order.
// ---------------------------------------------------------------------------
module tb;
  import eti_pkg::*;

  // Q8.24 constants
  localparam word_t QOne   = 32'sh0100_0000;
  localparam word_t QTwo   = 32'sh0200_0000;
  localparam word_t QThree = 32'sh0300_0000;
  localparam word_t QHalf  = 32'sh0080_0000;
  localparam radius_t RadiusFour = 31'h0400_0000;
  localparam radius_t RadiusTop  = {RadiusBits{1'b1}};

  // cycles with no accepted beat before the run is declared hung; the slowest
  // point is one that reaches the count limit
  localparam int HangLimit = 500000;
  // cycles the receiver holds off once to back the block up
  localparam int HoldCycles = 600;
  // result beat at which that hold-off starts
  localparam int HoldAtBeat = 50;

  typedef struct packed {
    logic   escaped;
    count_t iterations;
  } escape_result_t;

  // one entry of the stimulus plan: a point or a register write
  typedef struct {
    logic       is_cfg;
    cfg_index_t index;
    radius_t    value;
    word_t      c_real;
    word_t      c_imag;
  } job_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = CFG_MAX_ITER;
  logic [30:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;   // c_real[31:0], c_imag[63:32]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // iterations[15:0], escaped[16], zero[23:17]

  job_t           jobs[$];
  escape_result_t awaited[$];
  int             errors = 0;
  logic           stim_done = 1'b0;

  // register copies used by the predictor
  count_t  max_iter_cfg = MaxIterReset;
  radius_t radius_cfg   = RadiusReset;

  escape_time_iteration dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------------

  // clamp a wide value into the signed word range
  function automatic word_t clamp_word(input longint v);
    if (v > longint'(WordMax)) begin
      return WordMax;
    end else if (v < longint'(WordMin)) begin
      return WordMin;
    end
    return word_t'(v);
  endfunction

  // floor(a*b / 2^sh), saturated; the full product fits in 64 bits
  function automatic word_t scaled_product(input word_t a, input word_t b, input int sh);
    longint p;
    p = longint'(a) * longint'(b);
    return clamp_word(p >>> sh);
  endfunction

  // run the orbit of c from z = 0 under the current register copies
  function automatic escape_result_t iterate_point(input word_t cr, input word_t ci);
    word_t          zr;
    word_t          zi;
    word_t          xx;
    word_t          yy;
    word_t          mag;
    word_t          ny;
    int unsigned    n;
    logic           done;
    escape_result_t r;
    zr   = '0;
    zi   = '0;
    n    = 0;
    done = 1'b0;
    while (!done) begin
      xx  = scaled_product(zr, zr, FracBits);
      yy  = scaled_product(zi, zi, FracBits);
      mag = clamp_word(longint'(xx) + longint'(yy));
      // stop at the limit, at the counter ceiling, or once |z|^2 reaches the radius
      if (n >= max_iter_cfg || n >= CountMax || longint'(mag) >= longint'(radius_cfg)) begin
        done = 1'b1;
      end else begin
        // 2*x*y is the product shifted by one bit less
        ny = clamp_word(longint'(scaled_product(zr, zi, FracBits - 1)) + longint'(ci));
        zr = clamp_word(longint'(clamp_word(longint'(xx) - longint'(yy))) + longint'(cr));
        zi = ny;
        n++;
      end
    end
    r.iterations = n[CountBits-1:0];
    r.escaped    = (n < max_iter_cfg);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus plan
  // ---------------------------------------------------------------------------

  task automatic add_point(input word_t re, input word_t im);
    job_t j;
    j.is_cfg = 1'b0;
    j.index  = CFG_MAX_ITER;
    j.value  = '0;
    j.c_real = re;
    j.c_imag = im;
    jobs.push_back(j);
  endtask

  task automatic add_write(input cfg_index_t idx, input radius_t val);
    job_t j;
    j.is_cfg = 1'b1;
    j.index  = idx;
    j.value  = val;
    j.c_real = '0;
    j.c_imag = '0;
    jobs.push_back(j);
  endtask

  // a coordinate inside the box that holds the set: real -2.0 .. 0.5,
  // imaginary -1.25 .. 1.25
  function automatic word_t near_real();
    return word_t'(int'($urandom_range(0, 32'h0280_0000)) - 32'sh0200_0000);
  endfunction

  function automatic word_t near_imag();
    return word_t'(int'($urandom_range(0, 32'h0280_0000)) - 32'sh0140_0000);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present points from the plan, apply register writes once the
  // block has drained, and predict each accepted beat
  // ---------------------------------------------------------------------------
  logic fired;
  logic next_valid;
  logic next_we;
  int   in_flight = 0;
  int   flight;
  int   settle = 0;
  int   drive_cyc = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid  <= 1'b0;
      cfg_we    <= 1'b0;
      in_flight <= 0;
      stim_done <= 1'b0;
    end else begin
      fired = s_tvalid && s_tready;
      if (fired) begin
        awaited.push_back(iterate_point(word_t'(s_tdata[31:0]), word_t'(s_tdata[63:32])));
      end
      // track points inside the block from the port handshakes alone
      flight = in_flight + int'(fired) - int'(m_tvalid && m_tready);
      in_flight <= flight;
      drive_cyc++;
      next_valid = s_tvalid && !fired;
      next_we    = 1'b0;
      if (!next_valid && jobs.size() != 0) begin
        if (jobs[0].is_cfg) begin
          // write only after every point has returned and a short pause
          if (flight <= 0 && settle >= 4) begin
            next_we = 1'b1;
            cfg_index <= jobs[0].index;
            cfg_data  <= jobs[0].value;
            case (jobs[0].index)
              CFG_MAX_ITER: begin
                max_iter_cfg = jobs[0].value[CountBits-1:0];
              end
              CFG_RADIUS: begin
                radius_cfg = jobs[0].value;
              end
              default: begin
              end
            endcase
            void'(jobs.pop_front());
            settle = 0;
          end else begin
            settle = (flight <= 0) ? settle + 1 : 0;
          end
        end else if ((drive_cyc % 3000) >= 2000 || $urandom_range(99) >= 7) begin
          // idle now and then, except in the quiet window of each period
          next_valid = 1'b1;
          s_tdata <= {jobs[0].c_imag, jobs[0].c_real};
          void'(jobs.pop_front());
        end
      end
      s_tvalid  <= next_valid;
      cfg_we    <= next_we;
      stim_done <= (jobs.size() == 0) && !next_valid && (flight <= 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: drive tready and compare each result beat with the oldest
  // prediction
  // ---------------------------------------------------------------------------
  escape_result_t want;
  logic           ready_next;
  int             rx_cyc = 0;
  int             rx_beats = 0;
  int             hold_left = 0;
  logic           hold_used = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      rx_cyc++;
      if (m_tvalid && m_tready) begin
        rx_beats++;
        if (awaited.size() == 0) begin
          $display("%0t: unexpected result beat, iterations %0d escaped %0d",
                   $time, m_tdata[15:0], m_tdata[16]);
          errors++;
        end else begin
          want = awaited.pop_front();
          if (m_tdata[15:0] !== want.iterations) begin
            $display("%0t: iterations expected %0d actual %0d",
                     $time, want.iterations, m_tdata[15:0]);
            errors++;
          end
          if (m_tdata[16] !== want.escaped) begin
            $display("%0t: escaped expected %0d actual %0d", $time, want.escaped, m_tdata[16]);
            errors++;
          end
        end
      end
      // hold off once for a long stretch so the block fills and stalls its input
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if (!hold_used && rx_beats >= HoldAtBeat) begin
        hold_used  = 1'b1;
        hold_left  = HoldCycles - 1;
        ready_next = 1'b0;
      end else begin
        ready_next = (rx_cyc % 4000) >= 2500 || $urandom_range(99) >= 7;
      end
      m_tready <= ready_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run when nothing moves for too long
  // ---------------------------------------------------------------------------
  int quiet = 0;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet <= 0;
    end else if (quiet >= HangLimit) begin
      $display("%0t: no beat accepted for %0d cycles", $time, HangLimit);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Plan, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    // reset settings: limit 50000, radius 4.0
    add_point(QOne, '0);
    add_point(WordMax, WordMax);
    add_point(WordMin, WordMin);
    add_point(WordMin, WordMax);
    add_point(-QTwo, '0);          // |z|^2 lands exactly on the radius
    add_point(-QOne, '0);          // period-two orbit, runs to the limit

    // zero limit: no iteration, interior
    add_write(CFG_MAX_ITER, '0);
    add_point('0, '0);
    add_point(WordMax, WordMin);

    // zero radius: no iteration, exterior
    add_write(CFG_MAX_ITER, radius_t'(CountMax));
    add_write(CFG_RADIUS, '0);
    add_point(WordMin, '0);
    add_point(QHalf, -QHalf);

    // largest radius and limit: the counter ceiling and saturated magnitude
    add_write(CFG_RADIUS, RadiusTop);
    add_point('0, '0);
    add_point(WordMax, '0);
    add_point(WordMin, WordMin);

    // limit of one
    add_write(CFG_MAX_ITER, radius_t'(1));
    add_write(CFG_RADIUS, RadiusFour);
    add_point('0, '0);
    add_point(QThree, '0);
    add_point(QHalf, QHalf);

    // random phases, each with its own settings; most points lie near the set
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          add_write(CFG_MAX_ITER, radius_t'($urandom_range(2, 64)));
          add_write(CFG_RADIUS, RadiusFour);
        end
        1: begin
          add_write(CFG_MAX_ITER, radius_t'($urandom_range(1, 16)));
          add_write(CFG_RADIUS, radius_t'($urandom_range(32'h0010_0000, 32'h1000_0000)));
        end
        2: begin
          add_write(CFG_MAX_ITER, radius_t'($urandom_range(20, 80)));
          add_write(CFG_RADIUS, radius_t'($urandom_range(32'h0010_0000, 32'h1000_0000)));
        end
        default: begin
          add_write(CFG_MAX_ITER, radius_t'($urandom_range(2, 64)));
          add_write(CFG_RADIUS, radius_t'($urandom));
        end
      endcase
      for (int k = 0; k < 25; k++) begin
        if ($urandom_range(99) < 80) begin
          add_point(near_real(), near_imag());
        end else begin
          add_point(word_t'($urandom), word_t'($urandom));
        end
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    do begin
      @(posedge clk);
    end while (!stim_done);
    // drain: let any stray beat show up before the verdict
    repeat (20) @(posedge clk);

    if (awaited.size() != 0) begin
      $display("%0t: %0d predicted results never arrived", $time, awaited.size());
      errors++;
    end
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
sv/eti_pkg.sv
sv/eti_dp.sv
sv/eti_ctrl.sv
sv/escape_time_iteration.sv
tb/sv/tb.sv
